>>> hw/rtl/tlb_page_table_translator_core_defines.svh
// Assertion macros shared by the translator RTL.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_CORE_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TLBPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property in the cycle after each clock edge that sees reset.
`define TLBPT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (prop)) else $error(msg);

`endif

>>> hw/rtl/tlbpt_pkg.sv
// Types and fixed widths of the TLB and page-table translator.
package tlbpt_pkg;

    localparam int ADDR_W  = 16;
    localparam int TAG_W   = 8;
    localparam int FRAME_W = 8;
    localparam int CNT_W   = 32;

    typedef enum logic [1:0] {
        HIT_TLB   = 2'd0,
        HIT_MAP   = 2'd1,
        HIT_FAULT = 2'd2
    } t_hit_kind;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] logical_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] physical_address;
        t_hit_kind         hit_kind;
        logic [CNT_W-1:0]  tlb_hit_total;
        logic [CNT_W-1:0]  fault_total;
    } t_rsp;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } t_cam_look;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [FRAME_W-1:0] frame;
    } t_cam_fill;

    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } t_map_entry;

endpackage

>>> hw/rtl/tlbpt_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
interface tlbpt_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/tlbpt_cam.sv
// Fully associative TLB with FIFO fill.
`include "tlb_page_table_translator_core_defines.svh"

module tlbpt_cam #(
    parameter int TLB_ENTRIES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [tlbpt_pkg::TAG_W-1:0]       i_tag,
    output tlbpt_pkg::t_cam_look              o_look,
    input  logic                              i_fill_en,
    input  tlbpt_pkg::t_cam_fill              i_fill
);
    import tlbpt_pkg::*;

    localparam int SLOT_W = $clog2(TLB_ENTRIES);

    logic [TLB_ENTRIES-1:0] r_valid;
    logic [TAG_W-1:0]       r_tag   [TLB_ENTRIES];
    logic [FRAME_W-1:0]     r_frame [TLB_ENTRIES];
    logic [SLOT_W-1:0]      r_slot;
    logic [SLOT_W-1:0]      n_slot;
    logic [TLB_ENTRIES-1:0] w_hit_vec;
    logic [FRAME_W-1:0]     w_frame;

    always_comb begin
        w_hit_vec = '0;
        w_frame   = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            w_hit_vec[i] = r_valid[i] && (r_tag[i] == i_tag);
            if (w_hit_vec[i]) begin
                w_frame = w_frame | r_frame[i];
            end
        end
    end

    assign o_look.hit   = |w_hit_vec;
    assign o_look.frame = w_frame;

    always_comb begin
        if (r_slot == SLOT_W'(TLB_ENTRIES - 1)) begin
            n_slot = '0;
        end else begin
            n_slot = r_slot + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_slot  <= '0;
        end else if (i_fill_en) begin
            r_valid[r_slot] <= 1'b1;
            r_slot          <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fill_en) begin
            r_tag[r_slot]   <= i_fill.tag;
            r_frame[r_slot] <= i_fill.frame;
        end
    end

    `TLBPT_ASSERT(a_match_onehot, i_clk, i_rst_n, $onehot0(w_hit_vec), "duplicate TLB tag")
    `TLBPT_ASSERT(a_fill_on_miss, i_clk, i_rst_n, i_fill_en |-> !o_look.hit, "TLB fill on hit")

endmodule

>>> hw/rtl/tlbpt_map.sv
// Page-table memory with synchronous read and a clear sweep after reset.
module tlbpt_map #(
    parameter int PAGE_COUNT = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_rd_en,
    input  logic [$clog2(PAGE_COUNT)-1:0]        i_rd_idx,
    output tlbpt_pkg::t_map_entry                o_rd,
    input  logic                                 i_wr_en,
    input  logic [$clog2(PAGE_COUNT)-1:0]        i_wr_idx,
    input  tlbpt_pkg::t_map_entry                i_wr_entry,
    output logic                                 o_busy
);
    import tlbpt_pkg::*;

    localparam int IDX_W = $clog2(PAGE_COUNT);

    t_map_entry        r_mem [PAGE_COUNT];
    t_map_entry        r_rd;
    logic              r_busy;
    logic [IDX_W-1:0]  r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + IDX_W'(1);
            if (r_clr_idx == IDX_W'(PAGE_COUNT - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_idx];
        end
    end

    assign o_rd   = r_rd;
    assign o_busy = r_busy;

endmodule

>>> hw/rtl/tlb_page_table_translator_core.sv
// TLB and page-table address translator with demand paging.
// The accepted address is registered in the idle state; the lookup state writes
// the result to the output register once the output is free, and stalls until then.
// A new address is accepted only in the idle state, after the previous lookup commits.
// Reset: synchronous; the page table is swept clear entry by entry, then the core
// leaves the clear state; no address is accepted meanwhile.
`include "tlb_page_table_translator_core_defines.svh"

module tlb_page_table_translator_core #(
    parameter int TLB_ENTRIES  = 16,
    parameter int OFFSET_WIDTH = 8,
    parameter int PAGE_COUNT   = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlbpt_chan_if.sink  i_req,
    tlbpt_chan_if.source o_rsp
);
    import tlbpt_pkg::*;

    localparam int IDX_W = $clog2(PAGE_COUNT);
    localparam logic [31:0] OFF_MASK = (32'd1 << OFFSET_WIDTH) - 32'd1;

    t_state             r_state;
    t_state             n_state;
    logic [ADDR_W-1:0]  r_addr;
    logic [IDX_W-1:0]   r_page_idx;
    logic [FRAME_W-1:0] r_next_free;
    logic [CNT_W-1:0]   r_hit_cnt;
    logic [CNT_W-1:0]   r_fault_cnt;
    t_rsp               r_out;
    logic               r_out_valid;

    logic               w_in_fire;
    logic               w_out_fire;
    logic               w_done;
    logic               w_commit;
    logic [ADDR_W-1:0]  w_in_page;
    logic [IDX_W-1:0]   w_in_idx;
    t_cam_look          w_look;
    logic               w_fill_en;
    t_cam_fill          w_fill;
    t_map_entry         w_map_rd;
    logic               w_map_busy;
    logic               w_map_wr_en;
    t_map_entry         w_map_wr;
    t_hit_kind          w_kind;
    logic [FRAME_W-1:0] w_frame;
    logic [ADDR_W-1:0]  w_phys;
    logic [CNT_W-1:0]   w_hit_cnt;
    logic [CNT_W-1:0]   w_fault_cnt;

    assign w_in_fire  = i_req.valid && i_req.ready;
    assign w_out_fire = o_rsp.valid && o_rsp.ready;
    assign w_done     = !r_out_valid || o_rsp.ready;
    assign w_in_page  = i_req.payload.logical_address >> OFFSET_WIDTH;
    assign w_in_idx   = w_in_page[IDX_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (!w_map_busy) n_state = ST_IDLE;
            ST_IDLE:   if (w_in_fire) n_state = ST_LOOKUP;
            ST_LOOKUP: if (w_done) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        i_req.ready = 1'b0;
        w_commit    = 1'b0;
        case (r_state)
            ST_IDLE:   i_req.ready = 1'b1;
            ST_LOOKUP: w_commit = w_done;
            default: begin
                i_req.ready = 1'b0;
                w_commit    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_addr     <= i_req.payload.logical_address;
            r_page_idx <= w_in_idx;
        end
    end

    tlbpt_cam #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_cam (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (TAG_W'(r_page_idx)),
        .o_look    (w_look),
        .i_fill_en (w_fill_en),
        .i_fill    (w_fill)
    );

    tlbpt_map #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_in_fire),
        .i_rd_idx   (w_in_idx),
        .o_rd       (w_map_rd),
        .i_wr_en    (w_map_wr_en),
        .i_wr_idx   (r_page_idx),
        .i_wr_entry (w_map_wr),
        .o_busy     (w_map_busy)
    );

    always_comb begin
        if (w_look.hit) begin
            w_kind  = HIT_TLB;
            w_frame = w_look.frame;
        end else if (w_map_rd.valid) begin
            w_kind  = HIT_MAP;
            w_frame = w_map_rd.frame;
        end else begin
            w_kind  = HIT_FAULT;
            w_frame = r_next_free;
        end
    end

    assign w_fill_en      = w_commit && !w_look.hit;
    assign w_fill.tag     = TAG_W'(r_page_idx);
    assign w_fill.frame   = w_frame;
    assign w_map_wr_en    = w_commit && (w_kind == HIT_FAULT);
    assign w_map_wr.valid = 1'b1;
    assign w_map_wr.frame = r_next_free;

    assign w_phys = ADDR_W'((32'(w_frame) << OFFSET_WIDTH) | (32'(r_addr) & OFF_MASK));

    always_comb begin
        w_hit_cnt   = r_hit_cnt;
        w_fault_cnt = r_fault_cnt;
        if (w_kind == HIT_TLB && r_hit_cnt != '1) begin
            w_hit_cnt = r_hit_cnt + CNT_W'(1);
        end
        if (w_kind == HIT_FAULT && r_fault_cnt != '1) begin
            w_fault_cnt = r_fault_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= '0;
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_hit_cnt   <= w_hit_cnt;
            r_fault_cnt <= w_fault_cnt;
            r_out_valid <= 1'b1;
            if (w_kind == HIT_FAULT) begin
                r_next_free <= r_next_free + FRAME_W'(1);
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out.physical_address <= w_phys;
            r_out.hit_kind         <= w_kind;
            r_out.tlb_hit_total    <= w_hit_cnt;
            r_out.fault_total      <= w_fault_cnt;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    `TLBPT_ASSERT_RST(a_rst_to_clear, i_clk, i_rst_n, r_state == ST_CLEAR, "no clear after reset")
    `TLBPT_ASSERT(a_no_accept_clear, i_clk, i_rst_n, w_map_busy |-> !i_req.ready, "accept during clear")
    `TLBPT_ASSERT(a_rsp_from_lookup, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == ST_LOOKUP), "result without lookup")
    `TLBPT_ASSERT(a_fault_count, i_clk, i_rst_n, ($past(i_rst_n) && r_fault_cnt != $past(r_fault_cnt)) |-> ($past(w_commit) && r_out.hit_kind == HIT_FAULT), "fault count slip")

endmodule
